// ===== rtl/ccr_pkg.sv =====
package ccr_pkg;

    // Fixed-point format of positions, masses and accelerations.
    localparam int FRAC_BITS       = 16;
    localparam int EQUAL_TOLERANCE = 1;

    // Field widths.
    localparam int W      = 32;
    localparam int MASS_W = 31;

    // Unit vectors and mass shares are Q30 fractions no larger than one.
    localparam int U_FRAC = 30;
    localparam int Q_W    = U_FRAC + 1;

    // Squared separation and its floor square root.
    localparam int D2_W   = 2 * W + 1;
    localparam int DIST_W = (D2_W + 1) / 2;
    localparam int REM_W  = DIST_W + 2;

    // Divider operands: numerator is a magnitude shifted up by U_FRAC.
    localparam int NUM_W = W + U_FRAC;
    localparam int DEN_W = DIST_W;

    // Momentum magnitude (mass times acceleration, rescaled) and its halves.
    localparam int PROD_W = MASS_W + W - 1;
    localparam int PX_W   = PROD_W - FRAC_BITS;
    localparam int PXL_W  = PX_W / 2;
    localparam int PXH_W  = PX_W - PXL_W;

    // Magnitude of a dot product and its halves.
    localparam int DOT_W = PX_W + 1;
    localparam int DL_W  = DOT_W / 2;
    localparam int DH_W  = DOT_W - DL_W;

    // Squared cable length plus tolerance.
    localparam int                LIMIT_W = 2 * W;
    localparam logic [LIMIT_W-1:0] TOL_Q  = LIMIT_W'(EQUAL_TOLERANCE) << FRAC_BITS;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_CABLE_LENGTH  = 1'b0,
        REG_ENDS_ATTACHED = 1'b1
    } reg_idx_t;

endpackage

// ===== rtl/cable_constraint_resolve.sv =====
// Channel   Direction  Handshake            Contents
// input     in         in_valid / in_stall  positions, masses, accelerations of a body pair
// output    out        out_valid / out_stall applied flag, four impulses, four new positions
// config    in/out     psel/penable/pwrite  cable_length at 0x0, ends_attached at 0x4
//
// One item enters per cycle unless a stalled result holds the pipeline; each item passes through
// 3 front stages, 33 square-root stages, 31 divider stages, 6 back stages.
// Most of the depth comes from the bit-per-stage square root and the Q30 dividers.
// Reset clears the valid bits and the configuration registers.
// A stalled result holds the whole pipeline; in_stall is high exactly then.
module cable_constraint_resolve
    import ccr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Input channel.
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [W-1:0]      first_pos_x,
    input  logic signed [W-1:0]      first_pos_y,
    input  logic signed [W-1:0]      second_pos_x,
    input  logic signed [W-1:0]      second_pos_y,
    input  logic [MASS_W-1:0]        first_mass,
    input  logic [MASS_W-1:0]        second_mass,
    input  logic signed [W-1:0]      first_acc_x,
    input  logic signed [W-1:0]      first_acc_y,
    input  logic signed [W-1:0]      second_acc_x,
    input  logic signed [W-1:0]      second_acc_y,
    // Output channel.
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     applied,
    output logic signed [W-1:0]      first_impulse_x,
    output logic signed [W-1:0]      first_impulse_y,
    output logic signed [W-1:0]      second_impulse_x,
    output logic signed [W-1:0]      second_impulse_y,
    output logic signed [W-1:0]      first_new_x,
    output logic signed [W-1:0]      first_new_y,
    output logic signed [W-1:0]      second_new_x,
    output logic signed [W-1:0]      second_new_y,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int LAT = 9 + DIST_W + Q_W;

    typedef struct packed {
        logic signed [W-1:0]   x1;
        logic signed [W-1:0]   y1;
        logic signed [W-1:0]   x2;
        logic signed [W-1:0]   y2;
        logic                  dxn;
        logic                  dyn;
        logic [W-1:0]          adx;
        logic [W-1:0]          ady;
        logic [MASS_W-1:0]     m1;
        logic [MASS_W-1:0]     m2;
        logic [MASS_W:0]       msum;
        logic [3:0][W-1:0]     amag;
        logic [3:0]            aneg;
    } s1_t;

    typedef struct packed {
        logic signed [W-1:0]   x1;
        logic signed [W-1:0]   y1;
        logic signed [W-1:0]   x2;
        logic signed [W-1:0]   y2;
        logic                  dxn;
        logic                  dyn;
        logic [W-1:0]          adx;
        logic [W-1:0]          ady;
        logic [MASS_W-1:0]     m1;
        logic [MASS_W-1:0]     m2;
        logic [MASS_W:0]       msum;
        logic [3:0][PX_W-1:0]  pmag;
        logic [3:0]            aneg;
        logic                  ok;
    } sb1_t;

    typedef struct packed {
        logic signed [W-1:0]   x1;
        logic signed [W-1:0]   y1;
        logic signed [W-1:0]   x2;
        logic signed [W-1:0]   y2;
        logic                  dxn;
        logic                  dyn;
        logic [3:0][PX_W-1:0]  pmag;
        logic [3:0]            aneg;
        logic                  ok;
        logic [DIST_W-1:0]     sep_len;
    } sb2_t;

    // Clamp a signed value to the 32-bit range.
    function automatic logic [W-1:0] sat_pos(input logic [W+2:0] v);
        logic [3:0] top;
        top = v[W+2:W-1];
        if (top == 4'b0000 || top == 4'b1111)
            return v[W-1:0];
        else if (v[W+2])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

    // Apply a sign to a magnitude and clamp to the 32-bit range.
    function automatic logic [W-1:0] sat_mag(input logic neg, input logic [DOT_W-1:0] mag);
        logic [DOT_W-1:0] lim;
        lim = DOT_W'(1) << (W - 1);
        if (neg)
            return (mag > lim) ? {1'b1, {(W-1){1'b0}}} : (~mag[W-1:0] + 1'b1);
        else
            return (mag >= lim) ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [MASS_W-1:0]  cable_length_reg;
    logic               ends_attached_reg;
    logic [2*MASS_W-1:0] lensq_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cable_length_reg  <= '0;
            ends_attached_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_CABLE_LENGTH:  cable_length_reg  <= pwdata[MASS_W-1:0];
                REG_ENDS_ATTACHED: ends_attached_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_CABLE_LENGTH:  prdata = 32'(cable_length_reg);
            REG_ENDS_ATTACHED: prdata = 32'(ends_attached_reg);
            default:           prdata = '0;
        endcase
    end

    // Taut threshold, squared length plus tolerance.
    always_ff @(posedge clk)
    begin
        lensq_reg <= cable_length_reg * cable_length_reg;
        limit_reg <= LIMIT_W'(lensq_reg) + TOL_Q;
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together unless a result waits.
    // ------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // ------------------------------------------------------------------
    // Stage 1: separation magnitudes, mass sum, acceleration magnitudes.
    // ------------------------------------------------------------------
    s1_t             s1_next;
    s1_t             s1_reg;
    logic [W:0]      dx_a;
    logic [W:0]      dx_b;
    logic [W:0]      dy_a;
    logic [W:0]      dy_b;
    logic [3:0][W-1:0] acc_in;

    assign dx_a = {first_pos_x[W-1], first_pos_x} - {second_pos_x[W-1], second_pos_x};
    assign dx_b = {second_pos_x[W-1], second_pos_x} - {first_pos_x[W-1], first_pos_x};
    assign dy_a = {first_pos_y[W-1], first_pos_y} - {second_pos_y[W-1], second_pos_y};
    assign dy_b = {second_pos_y[W-1], second_pos_y} - {first_pos_y[W-1], first_pos_y};
    assign acc_in = {second_acc_y, second_acc_x, first_acc_y, first_acc_x};

    always_comb
    begin
        s1_next.x1   = first_pos_x;
        s1_next.y1   = first_pos_y;
        s1_next.x2   = second_pos_x;
        s1_next.y2   = second_pos_y;
        s1_next.dxn  = dx_a[W];
        s1_next.dyn  = dy_a[W];
        s1_next.adx  = dx_a[W] ? dx_b[W-1:0] : dx_a[W-1:0];
        s1_next.ady  = dy_a[W] ? dy_b[W-1:0] : dy_a[W-1:0];
        s1_next.m1   = first_mass;
        s1_next.m2   = second_mass;
        s1_next.msum = {1'b0, first_mass} + {1'b0, second_mass};
        for (int i = 0; i < 4; i++)
        begin
            s1_next.aneg[i] = acc_in[i][W-1];
            s1_next.amag[i] = acc_in[i][W-1] ? (~acc_in[i] + 1'b1) : acc_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s1_reg <= s1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the separation and momentum magnitudes.
    // ------------------------------------------------------------------
    sb1_t                   s2_reg;
    logic [2*W-1:0]         sx_reg;
    logic [2*W-1:0]         sy_reg;
    logic [3:0][PROD_W-1:0] pmag_prod;

    // Mass times acceleration magnitude for each body and axis.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            pmag_prod[i] = (i < 2 ? s1_reg.m1 : s1_reg.m2) * s1_reg.amag[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg     <= s1_reg.adx * s1_reg.adx;
            sy_reg     <= s1_reg.ady * s1_reg.ady;
            s2_reg.x1  <= s1_reg.x1;
            s2_reg.y1  <= s1_reg.y1;
            s2_reg.x2  <= s1_reg.x2;
            s2_reg.y2  <= s1_reg.y2;
            s2_reg.dxn <= s1_reg.dxn;
            s2_reg.dyn <= s1_reg.dyn;
            s2_reg.adx <= s1_reg.adx;
            s2_reg.ady <= s1_reg.ady;
            s2_reg.m1  <= s1_reg.m1;
            s2_reg.m2  <= s1_reg.m2;
            s2_reg.msum <= s1_reg.msum;
            s2_reg.aneg <= s1_reg.aneg;
            s2_reg.ok  <= ends_attached_reg && (cable_length_reg != '0)
                          && (s1_reg.msum != '0);
            for (int i = 0; i < 4; i++)
                s2_reg.pmag[i] <= pmag_prod[i][PROD_W-1:FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared separation.
    // ------------------------------------------------------------------
    sb1_t            s3_reg;
    logic [D2_W-1:0] d2_reg;
    logic            taut;
    sb1_t            sb1_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg <= {1'b0, sx_reg} + {1'b0, sy_reg};
            s3_reg <= s2_reg;
        end
    end

    assign taut = d2_reg > {1'b0, limit_reg};

    always_comb
    begin
        sb1_in    = s3_reg;
        sb1_in.ok = s3_reg.ok && taut;
    end

    // ------------------------------------------------------------------
    // Square root, with the item's other fields alongside.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] sep_len;
    sb1_t              sb1_reg [DIST_W];

    ccr_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (d2_reg),
        .root (sep_len)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb1_reg[0] <= sb1_in;
            for (int k = 1; k < DIST_W; k++)
                sb1_reg[k] <= sb1_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Unit vector and mass shares, four dividers in parallel.
    // ------------------------------------------------------------------
    sb1_t             sq;
    sb2_t             sb2_in;
    sb2_t             sb2_reg [Q_W];
    logic [Q_W-1:0]   q_ux;
    logic [Q_W-1:0]   q_uy;
    logic [Q_W-1:0]   q_r1;
    logic [Q_W-1:0]   q_r2;
    logic [DEN_W-1:0] msum_den;

    assign sq       = sb1_reg[DIST_W-1];
    assign msum_den = DEN_W'(sq.msum);

    ccr_div u_div_ux (
        .clk (clk),
        .en  (en),
        .num ({sq.adx, {U_FRAC{1'b0}}}),
        .den (sep_len),
        .quo (q_ux)
    );

    ccr_div u_div_uy (
        .clk (clk),
        .en  (en),
        .num ({sq.ady, {U_FRAC{1'b0}}}),
        .den (sep_len),
        .quo (q_uy)
    );

    ccr_div u_div_r1 (
        .clk (clk),
        .en  (en),
        .num (NUM_W'({sq.m1, {U_FRAC{1'b0}}})),
        .den (msum_den),
        .quo (q_r1)
    );

    ccr_div u_div_r2 (
        .clk (clk),
        .en  (en),
        .num (NUM_W'({sq.m2, {U_FRAC{1'b0}}})),
        .den (msum_den),
        .quo (q_r2)
    );

    always_comb
    begin
        sb2_in.x1      = sq.x1;
        sb2_in.y1      = sq.y1;
        sb2_in.x2      = sq.x2;
        sb2_in.y2      = sq.y2;
        sb2_in.dxn     = sq.dxn;
        sb2_in.dyn     = sq.dyn;
        sb2_in.pmag    = sq.pmag;
        sb2_in.aneg    = sq.aneg;
        sb2_in.ok      = sq.ok && (sep_len != '0);
        sb2_in.sep_len = sep_len;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb2_reg[0] <= sb2_in;
            for (int k = 1; k < Q_W; k++)
                sb2_reg[k] <= sb2_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Back stage 1: overshoot and split momentum-by-direction products.
    // ------------------------------------------------------------------
    sb2_t                  t1_sb_reg;
    logic [DIST_W-1:0]     t1_move_reg;
    logic [1:0][Q_W-1:0]   t1_u_reg;
    logic [Q_W-1:0]        t1_r1_reg;
    logic [Q_W-1:0]        t1_r2_reg;
    logic [1:0][Q_W-1:0]   umag;
    logic [DIST_W-1:0]     len_ext;
    sb2_t                  dv;

    assign dv      = sb2_reg[Q_W-1];
    assign umag    = {q_uy, q_ux};
    assign len_ext = DIST_W'(cable_length_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_sb_reg   <= dv;
            t1_move_reg <= (dv.sep_len >= len_ext) ? (dv.sep_len - len_ext) : '0;
            t1_u_reg    <= umag;
            t1_r1_reg   <= q_r1;
            t1_r2_reg   <= q_r2;
        end
    end

    logic [PXL_W+Q_W-1:0] t1_lo_reg [4];
    logic [PXH_W+Q_W-1:0] t1_hi_reg [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_t1
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t1_lo_reg[g] <= dv.pmag[g][PXL_W-1:0] * umag[g % 2];
                t1_hi_reg[g] <= dv.pmag[g][PX_W-1:PXL_W] * umag[g % 2];
            end
        end
    end

    // ------------------------------------------------------------------
    // Back stage 2: pulls and projected momentum magnitudes.
    // ------------------------------------------------------------------
    sb2_t                t2_sb_reg;
    logic [1:0][Q_W-1:0] t2_u_reg;
    logic [DIST_W-1:0]   t2_s1_reg;
    logic [DIST_W-1:0]   t2_s2_reg;
    logic [PX_W-1:0]     t2_tmag_reg [4];
    logic [DIST_W+Q_W-1:0] ms1;
    logic [DIST_W+Q_W-1:0] ms2;

    assign ms1 = t1_move_reg * t1_r1_reg;
    assign ms2 = t1_move_reg * t1_r2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_sb_reg <= t1_sb_reg;
            t2_u_reg  <= t1_u_reg;
            t2_s1_reg <= ms1[DIST_W+U_FRAC-1:U_FRAC];
            t2_s2_reg <= ms2[DIST_W+U_FRAC-1:U_FRAC];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_t2
        logic [PX_W+Q_W-1:0] tsum;
        assign tsum = {t1_hi_reg[g], {PXL_W{1'b0}}} + (PX_W+Q_W)'(t1_lo_reg[g]);

        always_ff @(posedge clk)
        begin
            if (en)
                t2_tmag_reg[g] <= tsum[PX_W+U_FRAC-1:U_FRAC];
        end
    end

    // ------------------------------------------------------------------
    // Back stage 3: signed projections and position moves.
    // ------------------------------------------------------------------
    sb2_t                t3_sb_reg;
    logic [1:0][Q_W-1:0] t3_u_reg;
    logic [PX_W:0]       t3_ts_reg [4];
    logic [DIST_W-1:0]   t3_mv_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_sb_reg <= t2_sb_reg;
            t3_u_reg  <= t2_u_reg;
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_t3
        logic                  tneg;
        logic [PX_W:0]         text;
        logic [DIST_W+Q_W-1:0] mvp;

        assign tneg = t2_sb_reg.aneg[g] ^ ((g % 2 == 0) ? t2_sb_reg.dxn : t2_sb_reg.dyn);
        assign text = {1'b0, t2_tmag_reg[g]};
        assign mvp  = ((g < 2) ? t2_s1_reg : t2_s2_reg) * t2_u_reg[g % 2];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t3_ts_reg[g] <= tneg ? (~text + 1'b1) : text;
                t3_mv_reg[g] <= mvp[DIST_W+U_FRAC-1:U_FRAC];
            end
        end
    end

    // ------------------------------------------------------------------
    // Back stage 4: dot products and corrected positions.
    // ------------------------------------------------------------------
    logic                 t4_ok_reg;
    logic                 t4_dxn_reg;
    logic                 t4_dyn_reg;
    logic [1:0][Q_W-1:0]  t4_u_reg;
    logic [1:0]           t4_dneg_reg;
    logic [DOT_W-1:0]     t4_dmag_reg [2];
    logic [W-1:0]         t4_pos_reg [4];
    logic [3:0][W-1:0]    pos_old;
    logic [3:0]           pos_sub;

    assign pos_old = {t3_sb_reg.y2, t3_sb_reg.x2, t3_sb_reg.y1, t3_sb_reg.x1};
    // The first body moves against the unit vector, the second along it.
    assign pos_sub = {t3_sb_reg.dyn, t3_sb_reg.dxn, !t3_sb_reg.dyn, !t3_sb_reg.dxn};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t4_ok_reg  <= t3_sb_reg.ok;
            t4_dxn_reg <= t3_sb_reg.dxn;
            t4_dyn_reg <= t3_sb_reg.dyn;
            t4_u_reg   <= t3_u_reg;
        end
    end

    for (genvar d = 0; d < 2; d++)
    begin : g_dot
        logic [PX_W+1:0] dsum;
        logic [PX_W+1:0] dneg_sum;
        logic [PX_W+1:0] ea;
        logic [PX_W+1:0] eb;

        assign ea       = {t3_ts_reg[2*d][PX_W], t3_ts_reg[2*d]};
        assign eb       = {t3_ts_reg[2*d+1][PX_W], t3_ts_reg[2*d+1]};
        assign dsum     = ea + eb;
        assign dneg_sum = -ea - eb;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t4_dneg_reg[d] <= dsum[PX_W+1];
                t4_dmag_reg[d] <= dsum[PX_W+1] ? dneg_sum[DOT_W-1:0] : dsum[DOT_W-1:0];
            end
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_pos
        logic [W+2:0] base;
        logic [W+2:0] step;
        logic [W+2:0] moved;

        assign base  = {{3{pos_old[g][W-1]}}, pos_old[g]};
        assign step  = (W+3)'(t3_mv_reg[g]);
        assign moved = pos_sub[g] ? (base - step) : (base + step);

        always_ff @(posedge clk)
        begin
            if (en)
                t4_pos_reg[g] <= t3_sb_reg.ok ? sat_pos(moved) : pos_old[g];
        end
    end

    // ------------------------------------------------------------------
    // Back stage 5: split dot-by-direction products.
    // ------------------------------------------------------------------
    logic                t5_ok_reg;
    logic [3:0]          t5_neg_reg;
    logic [W-1:0]        t5_pos_reg [4];
    logic [DL_W+Q_W-1:0] t5_lo_reg [4];
    logic [DH_W+Q_W-1:0] t5_hi_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t5_ok_reg  <= t4_ok_reg;
            t5_pos_reg <= t4_pos_reg;
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_t5
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t5_neg_reg[g] <= t4_dneg_reg[g / 2]
                                 ^ ((g % 2 == 0) ? t4_dxn_reg : t4_dyn_reg);
                t5_lo_reg[g]  <= t4_dmag_reg[g / 2][DL_W-1:0] * t4_u_reg[g % 2];
                t5_hi_reg[g]  <= t4_dmag_reg[g / 2][DOT_W-1:DL_W] * t4_u_reg[g % 2];
            end
        end
    end

    // ------------------------------------------------------------------
    // Back stage 6: impulses, saturation and the output register.
    // ------------------------------------------------------------------
    logic         applied_reg;
    logic [W-1:0] imp_reg [4];
    logic [W-1:0] pos_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            applied_reg <= t5_ok_reg;
            pos_reg     <= t5_pos_reg;
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_t6
        logic [DOT_W+Q_W-1:0] isum;
        assign isum = {t5_hi_reg[g], {DL_W{1'b0}}} + (DOT_W+Q_W)'(t5_lo_reg[g]);

        always_ff @(posedge clk)
        begin
            if (en)
                imp_reg[g] <= t5_ok_reg
                              ? sat_mag(t5_neg_reg[g], isum[DOT_W+U_FRAC-1:U_FRAC]) : '0;
        end
    end

    assign applied          = applied_reg;
    assign first_impulse_x  = imp_reg[0];
    assign first_impulse_y  = imp_reg[1];
    assign second_impulse_x = imp_reg[2];
    assign second_impulse_y = imp_reg[3];
    assign first_new_x      = pos_reg[0];
    assign first_new_y      = pos_reg[1];
    assign second_new_x     = pos_reg[2];
    assign second_new_y     = pos_reg[3];

endmodule

// ===== rtl/ccr_sqrt.sv =====
module ccr_sqrt
    import ccr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [D2_W-1:0]   rad,
    output logic [DIST_W-1:0] root
);

    // One result bit per stage, two radicand bits brought down each step.
    logic [REM_W-1:0]    rem_reg  [DIST_W];
    logic [DIST_W-1:0]   root_reg [DIST_W];
    logic [2*DIST_W-1:0] rad_reg  [DIST_W];

    for (genvar k = 0; k < DIST_W; k++)
    begin : g_stage
        logic [REM_W-1:0]    rem_prev;
        logic [DIST_W-1:0]   root_prev;
        logic [2*DIST_W-1:0] rad_prev;
        logic [REM_W-1:0]    rem_sh;
        logic [REM_W-1:0]    trial;
        logic                take;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = (2*DIST_W)'(rad);
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
        end

        // Trial subtraction of (4 * root + 1) from the shifted remainder.
        assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[2*DIST_W-1 -: 2]};
        assign trial  = {root_prev, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_prev[DIST_W-2:0], take};
                rad_reg[k]  <= {rad_prev[2*DIST_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[DIST_W-1];

endmodule

// ===== rtl/ccr_div.sv =====
module ccr_div
    import ccr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    // Restoring division, one quotient bit per stage. The quotient is known
    // to fit in Q_W bits, so the top numerator bits start as the remainder.
    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [Q_W-1:0]   low_prev;
        logic [Q_W-1:0]   quo_prev;
        logic [DEN_W-1:0] den_prev;
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W:0]   diff;
        logic             take;

        if (k == 0)
        begin : g_first
            assign rem_prev = DEN_W'(num[NUM_W-1:Q_W]);
            assign low_prev = num[Q_W-1:0];
            assign quo_prev = '0;
            assign den_prev = den;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign low_prev = low_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign den_prev = den_reg[k-1];
        end

        // Bring down the next numerator bit and try the subtraction.
        assign rem_sh = {rem_prev, low_prev[Q_W-1]};
        assign diff   = rem_sh - {1'b0, den_prev};
        assign take   = rem_sh >= {1'b0, den_prev};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                low_reg[k] <= {low_prev[Q_W-2:0], 1'b0};
                quo_reg[k] <= {quo_prev[Q_W-2:0], take};
                den_reg[k] <= den_prev;
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule
